// ----- hdl/rpp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared widths, constants and pipeline record types for the point rotator.
// ----------------------------------------------------------------------------
package rpp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRACTION_BITS = 16;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int ANGLE_W     = 19;
  localparam int ANGLE_SHIFT = 14;
  localparam int ZW          = 34;
  localparam int CW          = FRACTION_BITS + 3;
  localparam int PW          = DIFF_W + CW;
  localparam int SW          = PW + 1;
  localparam int RW          = SW - FRACTION_BITS + 1;

  // Cycles from the accepting edge to the edge at which the result is sampled.
  localparam int PIPE_LAT = CORDIC_STAGES + 5;

  localparam logic signed [ANGLE_W-1:0] ANGLE_PI_Q16  = 19'sd205887;
  localparam logic signed [ANGLE_W-1:0] ANGLE_NPI_Q16 = -19'sd205887;
  localparam logic signed [ZW-1:0]      PI_Q30        = 34'sd3373259426;
  localparam logic signed [ZW-1:0]      HALF_PI_Q30   = 34'sd1686629713;
  localparam logic signed [ZW-1:0]      NHALF_PI_Q30  = -34'sd1686629713;

  localparam longint GAIN_Q30    = 652032874;
  localparam longint X_INIT_L    = (GAIN_Q30 + (64'sd1 <<< (29 - FRACTION_BITS)))
                                   >>> (30 - FRACTION_BITS);
  localparam logic signed [CW-1:0] X_INIT = CW'(X_INIT_L);

  // Largest cosine magnitude that is still treated as zero (|c| * 10000 < 2^F).
  localparam int COS_ZERO_LIM = ((1 << FRACTION_BITS) - 1) / 10000;

  localparam logic [31:0] ATAN_TBL [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Values that ride along the CORDIC unchanged.
  typedef struct packed {
    logic                      err;
    logic                      neg;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

// ----- hdl/rpp_front.sv -----
// ----------------------------------------------------------------------------
// rpp_front
// Input stage: range check, angle widening and quadrant fold, point offsets.
// ----------------------------------------------------------------------------
module rpp_front import rpp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] pivot_x,
  input  logic signed [COORD_W-1:0] pivot_y,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      valid,
  output cordic_t                   cdata,
  output side_t                     side
);

  logic                 valid_r;
  cordic_t              cdata_r, cdata_nxt;
  side_t                side_r, side_nxt;
  logic signed [ZW-1:0] z_wide;

  always_comb begin
    z_wide = $signed({{(ZW-ANGLE_W){angle[ANGLE_W-1]}}, angle}) <<< ANGLE_SHIFT;
    side_nxt.err = (angle > ANGLE_PI_Q16) || (angle < ANGLE_NPI_Q16);
    side_nxt.cx  = pivot_x;
    side_nxt.cy  = pivot_y;
    side_nxt.dx  = $signed({point_x[COORD_W-1], point_x}) -
                   $signed({pivot_x[COORD_W-1], pivot_x});
    side_nxt.dy  = $signed({point_y[COORD_W-1], point_y}) -
                   $signed({pivot_y[COORD_W-1], pivot_y});
    cdata_nxt.x  = X_INIT;
    cdata_nxt.y  = '0;
    // Angles beyond a right angle run half a turn around, and the result is negated.
    priority if (z_wide > HALF_PI_Q30) begin
      cdata_nxt.z  = z_wide - PI_Q30;
      side_nxt.neg = 1'b1;
    end else if (z_wide < NHALF_PI_Q30) begin
      cdata_nxt.z  = z_wide + PI_Q30;
      side_nxt.neg = 1'b1;
    end else begin
      cdata_nxt.z  = z_wide;
      side_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cdata_r <= cdata_nxt;
      side_r  <= side_nxt;
    end
  end

  assign valid = valid_r;
  assign cdata = cdata_r;
  assign side  = side_r;

endmodule

// ----- hdl/rpp_cordic.sv -----
// ----------------------------------------------------------------------------
// rpp_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module rpp_cordic import rpp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_vld,
  input  cordic_t in_dat,
  input  side_t   in_side,
  output logic    out_vld,
  output cordic_t out_dat,
  output side_t   out_side
);

  logic [CORDIC_STAGES-1:0] vld_r;
  cordic_t                  dat_r   [CORDIC_STAGES];
  side_t                    side_r  [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] vld_in;
  cordic_t                  dat_in  [CORDIC_STAGES];
  side_t                    side_in [CORDIC_STAGES];
  cordic_t                  dat_nxt [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;

    if (i == 0) begin : g_first
      assign vld_in[i]  = in_vld;
      assign dat_in[i]  = in_dat;
      assign side_in[i] = in_side;
    end else begin : g_next
      assign vld_in[i]  = vld_r[i-1];
      assign dat_in[i]  = dat_r[i-1];
      assign side_in[i] = side_r[i-1];
    end

    always_comb begin
      xs = $signed(dat_in[i].x) >>> i;
      ys = $signed(dat_in[i].y) >>> i;
      at = $signed({{(ZW-32){1'b0}}, ATAN_TBL[i]});
      if (!dat_in[i].z[ZW-1]) begin
        dat_nxt[i].x = dat_in[i].x - ys;
        dat_nxt[i].y = dat_in[i].y + xs;
        dat_nxt[i].z = dat_in[i].z - at;
      end else begin
        dat_nxt[i].x = dat_in[i].x + ys;
        dat_nxt[i].y = dat_in[i].y - xs;
        dat_nxt[i].z = dat_in[i].z + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (vld_in[i]) begin
        dat_r[i]  <= dat_nxt[i];
        side_r[i] <= side_in[i];
      end
    end
  end

  assign out_vld  = vld_r[CORDIC_STAGES-1];
  assign out_dat  = dat_r[CORDIC_STAGES-1];
  assign out_side = side_r[CORDIC_STAGES-1];

endmodule

// ----- hdl/rpp_rotate.sv -----
// ----------------------------------------------------------------------------
// rpp_rotate
// Cosine cleanup, product terms, rounding, pivot add and saturation.
// ----------------------------------------------------------------------------
module rpp_rotate import rpp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  cordic_t                   in_dat,
  input  side_t                     in_side,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] rotated_x,
  output logic signed [COORD_W-1:0] rotated_y,
  output logic                      angle_error
);

  localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (FRACTION_BITS - 1);

  function automatic logic [COORD_W-1:0] sat32(input logic [RW-1:0] v);
    logic top_ok;
    top_ok = (v[RW-1:COORD_W-1] == '0) || (v[RW-1:COORD_W-1] == '1);
    if (top_ok) begin
      return v[COORD_W-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic [3:0] vld_r;

  // Stage 1: cos and sin with sign fix and small-cosine cleanup.
  logic signed [CW-1:0] cos_r, sin_r, cos_nxt, sin_nxt;
  logic        [CW-1:0] cos_abs;
  side_t                s1_side_r;

  // Stage 2: the four products.
  logic signed [PW-1:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  side_t                s2_side_r;

  // Stage 3: rounded sums.
  logic signed [SW-1:0] sum_x_r, sum_y_r;
  side_t                s3_side_r;

  // Stage 4: output registers.
  logic [COORD_W-1:0]   rx_r, ry_r, rx_nxt, ry_nxt;
  logic                 err_r;
  logic [RW-1:0]        rx_wide, ry_wide;
  logic [COORD_W-1:0]   px_back, py_back;

  always_comb begin
    cos_abs = in_dat.x[CW-1] ? CW'(-in_dat.x) : CW'(in_dat.x);
    cos_nxt = in_side.neg ? -in_dat.x : in_dat.x;
    sin_nxt = in_side.neg ? -in_dat.y : in_dat.y;
    if (cos_abs <= CW'(COS_ZERO_LIM)) begin
      cos_nxt = '0;
    end
  end

  always_comb begin
    rx_wide = $signed({{(RW-COORD_W){s3_side_r.cx[COORD_W-1]}}, s3_side_r.cx}) +
              $signed({sum_x_r[SW-1], sum_x_r[SW-1:FRACTION_BITS]});
    ry_wide = $signed({{(RW-COORD_W){s3_side_r.cy[COORD_W-1]}}, s3_side_r.cy}) +
              $signed({sum_y_r[SW-1], sum_y_r[SW-1:FRACTION_BITS]});
    // The untouched point is recovered as pivot plus offset.
    px_back = s3_side_r.cx + s3_side_r.dx[COORD_W-1:0];
    py_back = s3_side_r.cy + s3_side_r.dy[COORD_W-1:0];
    rx_nxt  = s3_side_r.err ? px_back : sat32(rx_wide);
    ry_nxt  = s3_side_r.err ? py_back : sat32(ry_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      cos_r     <= cos_nxt;
      sin_r     <= sin_nxt;
      s1_side_r <= in_side;
    end
    if (vld_r[0]) begin
      p_xc_r    <= s1_side_r.dx * cos_r;
      p_ys_r    <= s1_side_r.dy * sin_r;
      p_xs_r    <= s1_side_r.dx * sin_r;
      p_yc_r    <= s1_side_r.dy * cos_r;
      s2_side_r <= s1_side_r;
    end
    if (vld_r[1]) begin
      sum_x_r   <= SW'(p_xc_r) - SW'(p_ys_r) + HALF_LSB;
      sum_y_r   <= SW'(p_xs_r) + SW'(p_yc_r) + HALF_LSB;
      s3_side_r <= s2_side_r;
    end
    if (vld_r[2]) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      err_r <= s3_side_r.err;
    end
  end

  assign out_valid   = vld_r[3];
  assign rotated_x   = $signed(rx_r);
  assign rotated_y   = $signed(ry_r);
  assign angle_error = err_r;

endmodule

// ----- hdl/rotate_point_about_pivot.sv -----
// ----------------------------------------------------------------------------
// rotate_point_about_pivot
// Rotates a 2-D Q16.16 point about a pivot by a Q3.16 angle using a CORDIC.
// ----------------------------------------------------------------------------
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+--------------------
//  input    | in_point_x/y, in_pivot_x/y, in_angle       | start, busy
//  result   | out_rotated_x/y, out_angle_error           | out_valid strobe
//
// One item is taken every clock; busy stays low.
// Each item passes one input stage, the sixteen CORDIC micro-rotation stages
// and four stages for cosine cleanup, products, rounding and saturation.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module rotate_point_about_pivot import rpp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_pivot_x,
  input  logic signed [COORD_W-1:0] in_pivot_y,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_rotated_x,
  output logic signed [COORD_W-1:0] out_rotated_y,
  output logic                      out_angle_error
);

  logic    accept;
  logic    fr_vld, cd_vld;
  cordic_t fr_dat, cd_dat;
  side_t   fr_side, cd_side;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rpp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .point_x (in_point_x),
    .point_y (in_point_y),
    .pivot_x (in_pivot_x),
    .pivot_y (in_pivot_y),
    .angle   (in_angle),
    .valid   (fr_vld),
    .cdata   (fr_dat),
    .side    (fr_side)
  );

  rpp_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_dat   (fr_dat),
    .in_side  (fr_side),
    .out_vld  (cd_vld),
    .out_dat  (cd_dat),
    .out_side (cd_side)
  );

  rpp_rotate u_rotate (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (cd_vld),
    .in_dat      (cd_dat),
    .in_side     (cd_side),
    .out_valid   (out_valid),
    .rotated_x   (out_rotated_x),
    .rotated_y   (out_rotated_y),
    .angle_error (out_angle_error)
  );

`ifndef SYNTHESIS
  a_item_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("accepted item produced no result");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && rst_n, PIPE_LAT))
    else $error("result without a matching item");

  a_error_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_error ==
      (($past(in_angle, PIPE_LAT) > ANGLE_PI_Q16) ||
       ($past(in_angle, PIPE_LAT) < ANGLE_NPI_Q16))))
    else $error("angle error flag disagrees with the item's angle");

  a_error_passes_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_angle_error |->
      (out_rotated_x == $past(in_point_x, PIPE_LAT)) &&
      (out_rotated_y == $past(in_point_y, PIPE_LAT)))
    else $error("out-of-range angle did not return the point unchanged");
`endif

endmodule
